[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that must also hold while reset is active.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/crnc_pkg.sv]
// Package with constants, request types and sequencer codes of the notation converter.
package crnc_pkg;

	// Width of the row and column values; they saturate at all ones.
	localparam int VALUE_BITS = 24;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	// The digit stack holds the longest decimal string of a value (0.31 > log10(2)).
	localparam int STACK_DEPTH = (VALUE_BITS * 31) / 100 + 1;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	// Reciprocals for division by 10 and 26: quotient = (value * RECIP) >> SHIFT.
	// The rounding error of each reciprocal stays below 2^(SHIFT - VALUE_BITS),
	// so the quotient is exact for every value.
	localparam int RECIP_W = VALUE_BITS + 1;
	localparam int PROD_W = VALUE_BITS + RECIP_W;
	localparam int SHIFT_DEC = VALUE_BITS + 4;
	localparam int SHIFT_LET = VALUE_BITS + 5;
	localparam logic [RECIP_W-1:0] RECIP_DEC =
		RECIP_W'(((64'd1 << SHIFT_DEC) + 64'd9) / 64'd10);
	localparam logic [RECIP_W-1:0] RECIP_LET =
		RECIP_W'(((64'd1 << SHIFT_LET) + 64'd25) / 64'd26);

	// Character codes.
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_Z = 8'h5A;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;
	localparam logic [7:0] CHAR_R = 8'h52;
	localparam logic [7:0] CHAR_C = 8'h43;

	// Radixes of the letter and decimal forms.
	localparam logic [5:0] RADIX_DEC = 6'd10;
	localparam logic [5:0] RADIX_LET = 6'd26;

	// Index of the final output segment in each form.
	localparam logic [1:0] SEG_LAST_RC = 2'd1;
	localparam logic [1:0] SEG_LAST_A1 = 2'd3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} ref_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       overflow;
	} conv_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_PREP,
		ST_DIV,
		ST_REM,
		ST_PUT,
		ST_LIT
	} state_t;

	typedef enum logic [1:0] {
		SEG_LIT_R,
		SEG_LIT_C,
		SEG_LETTERS,
		SEG_DECIMAL
	} seg_kind_t;

	// Kind of output segment at a given position for the detected input form.
	function automatic seg_kind_t seg_kind(logic rc_form, logic [1:0] seg);
		seg_kind_t k;
		if (rc_form) begin
			k = (seg == 2'd0) ? SEG_LETTERS : SEG_DECIMAL;
		end else begin
			case (seg)
				2'd0: k = SEG_LIT_R;
				2'd1: k = SEG_DECIMAL;
				2'd2: k = SEG_LIT_C;
				default: k = SEG_DECIMAL;
			endcase
		end
		return k;
	endfunction

endpackage

[rtl/core/cell_reference_notation_converter_unit.sv]
// Cell reference converter between letters-digits and row-column notation.
// Each character that is not the final one is taken while idle, and the block stays ready.
// After the final character the block is busy: an R or C goes through START and LIT, and a value
// through START, then PREP, DIV and REM per digit or letter in the shared reciprocal divider,
// then PUT per character out while the output does not stall (up to 18 at VALUE_BITS = 24).
// Reset (arst_n low, asynchronous) clears the accumulated values and flags and returns to idle.
`include "assert_macros.svh"

module cell_reference_notation_converter_unit import crnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ref_valid,
	output logic       ref_stall,
	input  ref_item_t  ref_data,
	output logic       conv_valid,
	input  logic       conv_stall,
	output conv_item_t conv_data
);

	localparam int ACC_W = VALUE_BITS + 6;

	state_t                state_q, state_d;
	logic [1:0]            seg_q;
	logic [VALUE_BITS-1:0] letter_q, first_q, second_q;
	logic                  digit_seen_q, rc_form_q, sat_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [SP_W-1:0]       sp_q;
	logic [7:0]            stack_q [STACK_DEPTH];

	logic                  ref_accept, conv_accept;
	logic                  is_letter, is_digit, acc_en;
	logic [VALUE_BITS-1:0] acc_in, acc_new;
	logic [4:0]            acc_radix, acc_add;
	logic [7:0]            char_off;
	logic [ACC_W-1:0]      acc_sum;
	logic                  acc_ovf;

	seg_kind_t             kind;
	logic                  kind_letters, seg_last, val_zero;
	logic [RECIP_W-1:0]    div_recip;
	logic [PROD_W-1:0]     div_prod;
	logic [VALUE_BITS-1:0] div_quo;
	logic [VALUE_BITS-1:0] quo_scaled, rem_full;
	logic [4:0]            div_rem;
	logic [7:0]            digit_char;
	logic [SP_W-1:0]       sp_dec;
	logic [VALUE_BITS-1:0] seg_src;
	logic                  seg_adv, burst_done;

	assign ref_accept  = ref_valid && !ref_stall;
	assign conv_accept = conv_valid && !conv_stall;

	// Character classes and the saturating multiply-add for one input character.
	always_comb begin
		is_letter = (ref_data.in_char >= CHAR_A) && (ref_data.in_char <= CHAR_Z);
		is_digit  = (ref_data.in_char >= CHAR_0) && (ref_data.in_char <= CHAR_9);
		if (is_letter) begin
			acc_in    = letter_q;
			acc_radix = RADIX_LET[4:0];
			char_off  = ref_data.in_char - CHAR_A + 8'd1;
		end else begin
			acc_in    = rc_form_q ? second_q : first_q;
			acc_radix = RADIX_DEC[4:0];
			char_off  = ref_data.in_char - CHAR_0;
		end
		acc_add = char_off[4:0];
		acc_en  = is_digit || (is_letter && !digit_seen_q && !rc_form_q);
		acc_sum = ACC_W'(acc_in) * ACC_W'(acc_radix) + ACC_W'(acc_add);
		acc_ovf = acc_sum > ACC_W'(VALUE_MAX);
		acc_new = acc_ovf ? VALUE_MAX : acc_sum[VALUE_BITS-1:0];
	end

	// Segment decode, the shared reciprocal multiplier and the remainder step.
	always_comb begin
		kind         = seg_kind(rc_form_q, seg_q);
		kind_letters = (kind == SEG_LETTERS);
		seg_last     = rc_form_q ? (seg_q == SEG_LAST_RC) : (seg_q == SEG_LAST_A1);
		val_zero     = (val_q == '0);
		div_recip    = kind_letters ? RECIP_LET : RECIP_DEC;
		div_prod     = PROD_W'(val_q) * PROD_W'(div_recip);
		if (kind_letters) begin
			div_quo    = VALUE_BITS'(div_prod >> SHIFT_LET);
			quo_scaled = (quo_q << 4) + (quo_q << 3) + (quo_q << 1);
		end else begin
			div_quo    = VALUE_BITS'(div_prod >> SHIFT_DEC);
			quo_scaled = (quo_q << 3) + (quo_q << 1);
		end
		rem_full     = val_q - quo_scaled;
		div_rem      = rem_full[4:0];
		digit_char   = (kind_letters ? CHAR_A : CHAR_0) + {3'b000, div_rem};
		sp_dec       = sp_q - 1'b1;
		if (kind_letters) begin
			seg_src = second_q;
		end else if (!rc_form_q && (seg_q == SEG_LAST_A1)) begin
			seg_src = letter_q;
		end else begin
			seg_src = first_q;
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ref_valid && ref_data.in_last) state_d = ST_START;
			end
			ST_START: begin
				if (kind == SEG_LIT_R || kind == SEG_LIT_C) state_d = ST_LIT;
				else state_d = ST_PREP;
			end
			ST_PREP: begin
				if (kind_letters) begin
					if (!val_zero) state_d = ST_DIV;
					else if (sp_q == '0) state_d = ST_START;
					else state_d = ST_PUT;
				end else begin
					if (val_zero && sp_q != '0) state_d = ST_PUT;
					else state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				state_d = ST_REM;
			end
			ST_REM: begin
				state_d = ST_PREP;
			end
			ST_PUT: begin
				if (!conv_stall && sp_q == SP_W'(1)) state_d = seg_last ? ST_IDLE : ST_START;
			end
			ST_LIT: begin
				if (!conv_stall) state_d = ST_START;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs, result payload and sequencer strobes.
	always_comb begin
		ref_stall  = (state_q != ST_IDLE);
		conv_valid = (state_q == ST_PUT) || (state_q == ST_LIT);
		if (state_q == ST_LIT) begin
			conv_data.out_char = (kind == SEG_LIT_R) ? CHAR_R : CHAR_C;
		end else begin
			conv_data.out_char = stack_q[sp_dec[IDX_W-1:0]];
		end
		conv_data.out_last = (state_q == ST_PUT) && (sp_q == SP_W'(1)) && seg_last;
		conv_data.overflow = sat_q;
		burst_done = (state_q == ST_PUT) && !conv_stall && (sp_q == SP_W'(1)) && seg_last;
		seg_adv    = ((state_q == ST_PREP) && kind_letters && val_zero && (sp_q == '0))
			|| ((state_q == ST_PUT) && !conv_stall && (sp_q == SP_W'(1)) && !seg_last)
			|| ((state_q == ST_LIT) && !conv_stall);
	end

	// Control state, accumulated values and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seg_q        <= '0;
			sp_q         <= '0;
			letter_q     <= '0;
			first_q      <= '0;
			second_q     <= '0;
			digit_seen_q <= 1'b0;
			rc_form_q    <= 1'b0;
			sat_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			// Fold one input character into the values.
			if (ref_accept) begin
				if (is_letter) begin
					if (digit_seen_q) rc_form_q <= 1'b1;
					else if (!rc_form_q) letter_q <= acc_new;
				end else if (is_digit) begin
					if (rc_form_q) second_q <= acc_new;
					else first_q <= acc_new;
				end
				digit_seen_q <= is_digit;
				if (acc_en && acc_ovf) sat_q <= 1'b1;
			end

			// Start over once the last character of the burst is taken.
			if (burst_done) begin
				letter_q     <= '0;
				first_q      <= '0;
				second_q     <= '0;
				digit_seen_q <= 1'b0;
				rc_form_q    <= 1'b0;
				sat_q        <= 1'b0;
			end

			// Segment position within the output burst.
			if (state_q == ST_IDLE) seg_q <= '0;
			else if (seg_adv) seg_q <= seg_q + 2'd1;

			// Stack pointer: one push per remainder step, one pop per digit or letter out.
			if (state_q == ST_START) sp_q <= '0;
			else if (state_q == ST_REM) sp_q <= sp_q + 1'b1;
			else if (state_q == ST_PUT && conv_accept) sp_q <= sp_dec;
		end
	end

	// Divider operands and the digit stack.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				val_q <= seg_src;
			end
			ST_PREP: begin
				if (kind_letters && !val_zero) val_q <= val_q - 1'b1;
			end
			ST_DIV: begin
				quo_q <= div_quo;
			end
			ST_REM: begin
				val_q <= quo_q;
				stack_q[sp_q[IDX_W-1:0]] <= digit_char;
			end
			default: begin
			end
		endcase
	end

	`ASSERT_CLK(a_last_ends_burst, (conv_accept && conv_data.out_last) |=> (state_q == ST_IDLE), "burst did not end after its final character")
	`ASSERT_CLK(a_put_has_digit, (state_q == ST_PUT) |-> (sp_q != '0), "emitting from an empty digit stack")
	`ASSERT_CLK(a_final_starts_burst, (ref_accept && ref_data.in_last) |=> (state_q == ST_START), "final character did not start the output burst")
	`ASSERT_CLK(a_stack_bound, sp_q <= SP_W'(STACK_DEPTH), "digit stack overrun")

endmodule

[tb/crnc_conv_checker.sv]
// Checker that predicts each converted cell reference and compares it with the block output.
`timescale 1ns / 100ps

module crnc_conv_checker import crnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ref_valid,
	input  logic       ref_stall,
	input  ref_item_t  ref_data,
	input  logic       conv_valid,
	input  logic       conv_stall,
	input  conv_item_t conv_data,
	output int         errors,
	output int         pending
);

	// Predicted parser state for the reference being collected.
	logic [VALUE_BITS-1:0] letter_acc;
	logic [VALUE_BITS-1:0] row_acc;
	logic [VALUE_BITS-1:0] col_acc;
	bit after_digit;
	bit rc_form;
	bit clipped;

	// Converted characters that are still due, oldest first.
	conv_item_t expected_chars[$];
	logic [7:0] conv_text[$];
	int err_count = 0;

	// Clears the parser state, as after reset and after each final character.
	function automatic void clear_state();
		letter_acc = '0;
		row_acc = '0;
		col_acc = '0;
		after_digit = 1'b0;
		rc_form = 1'b0;
		clipped = 1'b0;
	endfunction

	// Multiplies and adds, holding the result at the maximum value on overflow.
	function automatic logic [VALUE_BITS-1:0] grow(input logic [VALUE_BITS-1:0] acc,
			input int unsigned radix, input int unsigned add);
		longint unsigned sum;
		sum = acc;
		sum = sum * radix + add;
		if (sum > VALUE_MAX) begin
			clipped = 1'b1;
			return VALUE_MAX;
		end
		return sum[VALUE_BITS-1:0];
	endfunction

	// Appends the decimal digits of a value; zero gives a single digit.
	function automatic void add_decimal(input logic [VALUE_BITS-1:0] value);
		logic [7:0] digits[$];
		int unsigned n;
		n = value;
		do begin
			digits.push_front(CHAR_0 + 8'(n % RADIX_DEC));
			n = n / RADIX_DEC;
		end while (n != 0);
		foreach (digits[k]) conv_text.push_back(digits[k]);
	endfunction

	// Appends the bijective base-26 letters of a value; zero gives no letters.
	function automatic void add_letters(input logic [VALUE_BITS-1:0] value);
		logic [7:0] letters[$];
		int unsigned n;
		n = value;
		while (n != 0) begin
			n = n - 1;
			letters.push_front(CHAR_A + 8'(n % RADIX_LET));
			n = n / RADIX_LET;
		end
		foreach (letters[k]) conv_text.push_back(letters[k]);
	endfunction

	// Parses one accepted request and, on the final character, queues the conversion.
	function automatic void take_ref(input ref_item_t req);
		logic [7:0] c;
		conv_item_t item;
		c = req.in_char;
		if (c >= CHAR_A && c <= CHAR_Z) begin
			if (after_digit) begin
				rc_form = 1'b1;
			end else if (!rc_form) begin
				letter_acc = grow(letter_acc, RADIX_LET, c - CHAR_A + 1);
			end
			after_digit = 1'b0;
		end else if (c >= CHAR_0 && c <= CHAR_9) begin
			if (rc_form) begin
				col_acc = grow(col_acc, RADIX_DEC, c - CHAR_0);
			end else begin
				row_acc = grow(row_acc, RADIX_DEC, c - CHAR_0);
			end
			after_digit = 1'b1;
		end else begin
			after_digit = 1'b0;
		end
		if (!req.in_last) return;

		// Row-column input turns into letters and row; the other form into R, row, C, column.
		conv_text.delete();
		if (rc_form) begin
			add_letters(col_acc);
			add_decimal(row_acc);
		end else begin
			conv_text.push_back(CHAR_R);
			add_decimal(row_acc);
			conv_text.push_back(CHAR_C);
			add_decimal(letter_acc);
		end
		foreach (conv_text[k]) begin
			item.out_char = conv_text[k];
			item.out_last = (k == conv_text.size() - 1);
			item.overflow = clipped;
			expected_chars.push_back(item);
		end
		clear_state();
	endfunction

	// Prints one mismatch line and counts it; printing stops after the first hundred.
	task automatic report(input string what);
		err_count++;
		if (err_count <= 100) $display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	// Watches both channels at each edge and compares results with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		conv_item_t want;
		if (!arst_n) begin
			clear_state();
			expected_chars.delete();
		end else begin
			if (ref_valid && !ref_stall) take_ref(ref_data);
			if (conv_valid && !conv_stall) begin
				if (expected_chars.size() == 0) begin
					report($sformatf("unexpected character %h", conv_data.out_char));
				end else begin
					want = expected_chars.pop_front();
					if (conv_data.out_char !== want.out_char)
						report($sformatf("out_char %h, expected %h",
							conv_data.out_char, want.out_char));
					if (conv_data.out_last !== want.out_last)
						report($sformatf("out_last %b, expected %b on %h",
							conv_data.out_last, want.out_last, want.out_char));
					if (conv_data.overflow !== want.overflow)
						report($sformatf("overflow %b, expected %b on %h",
							conv_data.overflow, want.overflow, want.out_char));
				end
			end
		end
		errors <= err_count;
		pending <= expected_chars.size();
	end

endmodule

[tb/tb.sv]
// Testbench top for the converter: clock, reset, request stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb;
	import crnc_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ref_valid = 1'b0;
	logic ref_stall;
	ref_item_t ref_data = '0;
	logic conv_valid;
	logic conv_stall = 1'b0;
	conv_item_t conv_data;
	int errors;
	int pending;

	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int cycles = 0;
	int items_sent = 0;
	logic [7:0] ref_text[$];

	cell_reference_notation_converter_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.ref_valid  (ref_valid),
		.ref_stall  (ref_stall),
		.ref_data   (ref_data),
		.conv_valid (conv_valid),
		.conv_stall (conv_stall),
		.conv_data  (conv_data)
	);

	crnc_conv_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ref_valid  (ref_valid),
		.ref_stall  (ref_stall),
		.ref_data   (ref_data),
		.conv_valid (conv_valid),
		.conv_stall (conv_stall),
		.conv_data  (conv_data),
		.errors     (errors),
		.pending    (pending)
	);

	// Free-running clock with a 4 ns period.
	initial begin
		forever #2 clk = ~clk;
	end

	// Cycle counter that ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off counted here once requested.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				conv_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				conv_stall <= 1'b1;
			end else begin
				conv_stall <= idle_en && ($urandom_range(0, 99) < 25);
			end
		end
	end

	function automatic logic [7:0] rand_letter();
		return CHAR_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CHAR_0 + 8'($urandom_range(0, 9));
	endfunction

	// Mostly short lengths, sometimes long enough to saturate a value.
	function automatic int pick_len(input int short_max, input int long_max);
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, short_max);
		return $urandom_range(short_max + 1, long_max);
	endfunction

	// Offers one request, with random idle cycles first, and waits until it is taken.
	task automatic send_char(input ref_item_t req);
		while (idle_en && $urandom_range(0, 99) < 25) begin
			ref_valid <= 1'b0;
			@(posedge clk);
		end
		ref_valid <= 1'b1;
		ref_data <= req;
		do @(posedge clk); while (ref_stall);
		items_sent++;
	endtask

	// Sends the characters held in ref_text, marking the final one.
	task automatic send_ref();
		ref_item_t req;
		foreach (ref_text[k]) begin
			req.in_char = ref_text[k];
			req.in_last = (k == ref_text.size() - 1);
			send_char(req);
		end
	endtask

	task automatic send_text(input string s);
		ref_text.delete();
		for (int k = 0; k < s.len(); k++) ref_text.push_back(s[k]);
		send_ref();
	endtask

	// Builds a random reference: mostly well formed in either notation, some noise.
	task automatic build_random_ref();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		ref_text.delete();
		if (kind < 40) begin
			if ($urandom_range(0, 3) == 0) ref_text.push_back(CHAR_DOLLAR);
			n = pick_len(3, 7);
			repeat (n) ref_text.push_back(rand_letter());
			if ($urandom_range(0, 3) == 0) ref_text.push_back(CHAR_DOLLAR);
			n = pick_len(4, 9);
			repeat (n) ref_text.push_back(rand_digit());
		end else if (kind < 80) begin
			ref_text.push_back(CHAR_R);
			n = pick_len(4, 9);
			repeat (n) ref_text.push_back(rand_digit());
			ref_text.push_back(CHAR_C);
			n = pick_len(4, 9);
			repeat (n) ref_text.push_back(rand_digit());
			if ($urandom_range(0, 4) == 0) ref_text.push_back(rand_letter());
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				case ($urandom_range(0, 2))
					0: ref_text.push_back(8'($urandom_range(0, 255)));
					1: ref_text.push_back(rand_letter());
					default: ref_text.push_back(rand_digit());
				endcase
			end
		end
	endtask

	// Reset, directed references, random references, then drain and verdict.
	initial begin
		int refs;
		int base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes at both ends of the range are ignored around a plain reference.
		ref_text = {8'h00, CHAR_A, 8'hFF, CHAR_0 + 8'd1};
		send_ref();
		// Row-column form turns into letters and row.
		send_text("R23C55");
		// A zero row comes out as one digit.
		send_text("Z0");
		// A letter after the form is known is ignored, and a zero column gives no letters.
		send_text("R0CQ0");
		// A row that saturates sets the overflow flag.
		send_text("A99999999");

		base = items_sent;
		refs = 0;
		while (items_sent < base + RANDOM_ITEMS) begin
			if (refs == 5) hold_req <= 1'b1;
			idle_en <= !(refs >= 20 && refs < 40);
			build_random_ref();
			send_ref();
			refs++;
		end
		ref_valid <= 1'b0;

		// Wait for every expected character, then for the block to settle.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
